// ===== rtl/core/u8d_pkg.sv =====
// Shared word types and constants of the UTF-8 stream decoder.
package u8d_pkg;

    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT = 8'hF8;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
    localparam logic [6:0] CASE_OFFSET   = 7'h20;

    localparam int HELD_DEPTH = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        run_last;
        logic        string_last;
    } t_out_word;

    typedef struct packed {
        logic [1:0]             flush_n;
        logic [2:0][7:0]        flush_bytes;
        logic                   has_final;
        logic [20:0]            final_cp;
        logic [2:0]             final_cnt;
        logic                   string_end;
    } t_job;

endpackage

// ===== rtl/core/u8d_front.sv =====
// Front end: accepts bytes, tracks held sequence bytes, builds emit jobs.
module u8d_front
    import u8d_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_in,
    output logic     o_ready,
    input  logic     i_queue_ready,
    output logic     o_push,
    output t_job     o_job
);

    logic [HELD_DEPTH-1:0][7:0] r_held, n_held;
    logic [1:0]                 r_held_cnt, n_held_cnt;

    logic       accept;
    logic [7:0] b;
    logic       e;
    logic       is_cont;
    logic       is_lead;
    logic       fresh;
    logic [2:0] need;
    logic [5:0] c1, c2, cb;
    logic [20:0] cp;
    logic [2:0] total;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && o_ready;
    assign b       = i_in.in_byte;
    assign e       = i_in.string_end;
    assign is_cont = (b[7:6] == CONT_TAG);
    assign is_lead = (b >= LEAD_MIN) && (b < LEAD_LIMIT);
    assign c1      = r_held[1][5:0];
    assign c2      = r_held[2][5:0];
    assign cb      = b[5:0];

    always_comb begin
        if (r_held[0] < LEAD3_MIN) begin
            need = 3'd2;
        end else if (r_held[0] < LEAD4_MIN) begin
            need = 3'd3;
        end else begin
            need = 3'd4;
        end
    end

    always_comb begin
        case (need)
            3'd2:    cp = {10'd0, r_held[0][4:0], cb};
            3'd3:    cp = {5'd0, r_held[0][3:0], c1, cb};
            default: cp = {r_held[0][2:0], c1, c2, cb};
        endcase
    end

    always_comb begin
        n_held      = r_held;
        n_held_cnt  = r_held_cnt;
        fresh       = 1'b1;
        o_job       = '0;
        o_job.flush_bytes = r_held;
        o_job.string_end  = e;
        if (r_held_cnt != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (({1'b0, r_held_cnt} + 3'd1) >= need) begin
                    o_job.has_final = 1'b1;
                    o_job.final_cp  = cp;
                    o_job.final_cnt = need;
                    n_held_cnt      = 2'd0;
                end else begin
                    n_held[r_held_cnt] = b;
                    n_held_cnt         = r_held_cnt + 2'd1;
                    if (e) begin
                        o_job.flush_n     = r_held_cnt + 2'd1;
                        o_job.flush_bytes = n_held;
                        n_held_cnt        = 2'd0;
                    end
                end
            end else begin
                o_job.flush_n = r_held_cnt;
                n_held_cnt    = 2'd0;
            end
        end
        if (fresh) begin
            if (is_lead && !e) begin
                n_held[0]  = b;
                n_held_cnt = 2'd1;
            end else begin
                o_job.has_final = 1'b1;
                o_job.final_cp  = {13'd0, b};
                o_job.final_cnt = 3'd1;
            end
        end
    end

    assign total  = {1'b0, o_job.flush_n} + {2'd0, o_job.has_final};
    assign o_push = accept && (total != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
        end else if (accept) begin
            r_held_cnt <= n_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    a_held_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_cnt != 2'd0) |-> ((r_held[0] >= LEAD_MIN) && (r_held[0] < LEAD_LIMIT)))
        else $error("held sequence does not start with a lead byte");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && e) |-> (o_push && n_held_cnt == 2'd0))
        else $error("string end left bytes held or emitted nothing");

endmodule

// ===== rtl/core/u8d_queue.sv =====
// Job queue between the front end and the emit stage.
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_not_full,
    output logic o_head_valid,
    output t_job o_head,
    input  logic i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_not_full   = (r_count != CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_not_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_not_full)
        else $error("push into full queue");

endmodule

// ===== rtl/core/u8d_back.sv =====
// Emit stage: expands each queued job into code point words.
module u8d_back
    import u8d_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_upper_case,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_word o_out,
    input  logic      i_ready
);

    logic [1:0]  r_idx;
    logic        r_valid;
    t_out_word   r_out;
    logic [2:0]  total;
    logic        last;
    logic        load;
    logic [20:0] raw_cp;
    logic [20:0] cur_cp;
    logic [2:0]  cur_cnt;

    assign total = {1'b0, i_head.flush_n} + {2'd0, i_head.has_final};
    assign last  = (({1'b0, r_idx} + 3'd1) == total);
    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load && last;

    always_comb begin
        if (r_idx < i_head.flush_n) begin
            case (r_idx)
                2'd0:    raw_cp = {13'd0, i_head.flush_bytes[0]};
                2'd1:    raw_cp = {13'd0, i_head.flush_bytes[1]};
                default: raw_cp = {13'd0, i_head.flush_bytes[2]};
            endcase
            cur_cnt = 3'd1;
        end else begin
            raw_cp  = i_head.final_cp;
            cur_cnt = i_head.final_cnt;
        end
        cur_cp = raw_cp;
        if (i_upper_case && (raw_cp >= {14'd0, ASCII_LOWER_A})
                && (raw_cp <= {14'd0, ASCII_LOWER_Z})) begin
            cur_cp = raw_cp - {14'd0, CASE_OFFSET};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.code_point  <= cur_cp;
            r_out.byte_count  <= cur_cnt;
            r_out.run_last    <= last;
            r_out.string_last <= last && i_head.string_end;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < total))
        else $error("emit index beyond job length");

    a_idx_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == 2'd0))
        else $error("emit index left mid-job with empty queue");

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
//
// Takes one byte per cycle while the queue has room and emits one code point
// word per cycle while the output is ready, with byte count and run/string
// markers. A byte produces zero to four words: a completed sequence or a
// single byte gives one, while a broken sequence or an end of string with
// bytes held flushes each held byte as its own word. The front end turns
// each byte that yields words into a job in a QUEUE_DEPTH-entry queue; the
// emit stage drains it into its output register, and the input stalls only
// when flush bursts or a stalled output fill the queue. upper_case may be
// changed only while the block is idle.
module utf8_stream_decoder
    import u8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_valid,
    input  t_in_word  i_in,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_word o_out,
    input  logic      i_ready
);

    logic r_upper_case;
    logic queue_ready;
    logic push;
    t_job push_job;
    logic head_valid;
    t_job head;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_case <= 1'b0;
        end else if (i_cfg_we) begin
            r_upper_case <= i_cfg_wdata;
        end
    end

    u8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_in          (i_in),
        .o_ready       (o_ready),
        .i_queue_ready (queue_ready),
        .o_push        (push),
        .o_job         (push_job)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_not_full   (queue_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_upper_case (r_upper_case),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_out        (o_out),
        .i_ready      (i_ready)
    );

endmodule

// ===== verif/utf8_stream_decoder_test.sv =====
// Self-checking testbench of the UTF-8 stream decoder with a behavioral code point predictor.
module utf8_stream_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;
    import u8d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_BYTES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_valid = 1'b0;
    t_in_word  i_in = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_word o_out;
    logic      i_ready = 1'b0;

    logic [7:0]  held_q [HELD_DEPTH];
    int unsigned held_n = 0;
    logic        upper_mode = 1'b0;
    t_out_word   step_words [$];
    t_out_word   pending_cps [$];

    logic        idle_on = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned words_checked = 0;
    int unsigned cfg_writes = 0;

    utf8_stream_decoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_ready     (i_ready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf8_stream_decoder regression: fail");
            $finish;
        end
    end

    function automatic void emit_cp(input logic [20:0] cp, input logic [2:0] n);
        t_out_word w;
        if (upper_mode && cp >= {14'd0, ASCII_LOWER_A} && cp <= {14'd0, ASCII_LOWER_Z}) begin
            cp = cp - {14'd0, CASE_OFFSET};
        end
        w.code_point  = cp;
        w.byte_count  = n;
        w.run_last    = 1'b0;
        w.string_last = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_n; i++) begin
            emit_cp({13'd0, held_q[i]}, 3'd1);
        end
        held_n = 0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic e);
        int unsigned need;
        logic        fresh;
        logic [20:0] cp;
        fresh = 1'b1;
        step_words.delete();
        if (held_n > 0) begin
            if (b[7:6] == CONT_TAG) begin
                fresh = 1'b0;
                need = (held_q[0] < LEAD3_MIN) ? 2 : (held_q[0] < LEAD4_MIN) ? 3 : 4;
                if (held_n + 1 >= need) begin
                    case (need)
                        2: cp = {10'd0, held_q[0][4:0], b[5:0]};
                        3: cp = {5'd0, held_q[0][3:0], held_q[1][5:0], b[5:0]};
                        default: cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};
                    endcase
                    emit_cp(cp, 3'(need));
                    held_n = 0;
                end else begin
                    held_q[held_n] = b;
                    held_n++;
                    if (e) begin
                        flush_held();
                    end
                end
            end else begin
                flush_held();
            end
        end
        if (fresh) begin
            if (b >= LEAD_MIN && b < LEAD_LIMIT) begin
                if (e) begin
                    emit_cp({13'd0, b}, 3'd1);
                end else begin
                    held_q[0] = b;
                    held_n = 1;
                end
            end else begin
                emit_cp({13'd0, b}, 3'd1);
            end
        end
        if (step_words.size() > 0) begin
            step_words[step_words.size() - 1].run_last    = 1'b1;
            step_words[step_words.size() - 1].string_last = e;
        end
        foreach (step_words[i]) begin
            pending_cps.push_back(step_words[i]);
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic e);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in.in_byte    <= b;
        i_in.string_end <= e;
        do @(posedge i_clk); while (!o_ready);
        decode_byte(b, e);
        bytes_sent++;
    endtask

    task automatic drain_words();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_cps.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic set_upper_case(input logic v);
        drain_words();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        upper_mode = v;
        cfg_writes++;
    endtask

    initial begin
        int unsigned stall;
        t_out_word   got;
        t_out_word   want;
        wait (i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = o_out;
            words_checked++;
            if (pending_cps.size() == 0) begin
                $error("unexpected word: code_point %06h", got.code_point);
                fail_count++;
            end else begin
                want = pending_cps.pop_front();
                if (got.code_point != want.code_point) begin
                    $error("code_point: expected %06h, got %06h", want.code_point,
                           got.code_point);
                    fail_count++;
                end
                if (got.byte_count != want.byte_count) begin
                    $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
                    fail_count++;
                end
                if (got.run_last != want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                    fail_count++;
                end
                if (got.string_last != want.string_last) begin
                    $error("string_last: expected %0b, got %0b", want.string_last,
                           got.string_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_single_bytes();
        idle_on = 1'b1;
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b1);
        send_word(8'h80, 1'b0);
    endtask

    task automatic test_complete_sequences();
        idle_on = 1'b0;
        send_word(8'hC0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hDF, 1'b0);
        send_word(8'hBF, 1'b1);
        send_word(8'hEF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hF7, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b1);
        idle_on = 1'b1;
    endtask

    task automatic test_broken_sequences();
        send_word(8'hF0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b1);
        send_word(8'hC3, 1'b1);
        send_word(8'hC3, 1'b0);
        send_word(8'hF8, 1'b0);
    endtask

    task automatic test_upper_case();
        set_upper_case(1'b1);
        send_word(8'h7A, 1'b0);
        send_word(8'hC1, 1'b0);
        send_word(8'hA1, 1'b1);
        set_upper_case(1'b0);
    endtask

    task automatic test_random_stream();
        int unsigned random_bytes;
        int unsigned next_cfg;
        int unsigned kind;
        int unsigned len;
        int unsigned keep;
        logic [7:0]  seq [4];
        logic        e;
        random_bytes = 0;
        next_cfg = 60;
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                idle_on = ~idle_on;
            end
            if (random_bytes >= next_cfg) begin
                set_upper_case(1'($urandom_range(0, 1)));
                next_cfg += 60;
            end
            kind = $urandom_range(0, 9);
            if (kind >= 8) begin
                send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                random_bytes++;
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: seq[0] = 8'($urandom_range(0, 127));
                    2: seq[0] = 8'($urandom_range(LEAD_MIN, LEAD3_MIN - 1));
                    3: seq[0] = 8'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
                    default: seq[0] = 8'($urandom_range(LEAD4_MIN, LEAD_LIMIT - 1));
                endcase
                for (int i = 1; i < 4; i++) begin
                    seq[i] = {CONT_TAG, 6'($urandom_range(0, 63))};
                end
                keep = (kind >= 6 && len > 1) ? $urandom_range(1, len - 1) : len;
                e = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < keep; i++) begin
                    send_word(seq[i], e && (i == keep - 1));
                end
                random_bytes += keep;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_single_bytes();
        test_complete_sequences();
        test_broken_sequences();
        test_upper_case();
        test_random_stream();
        drain_words();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        $display("%0d bytes sent, %0d code point words checked", bytes_sent, words_checked);
        $display("%0d upper-case register writes, %0d mismatches", cfg_writes, fail_count);
        if (fail_count == 0) begin
            $display("utf8_stream_decoder regression: pass");
        end else begin
            $display("utf8_stream_decoder regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/u8d_pkg.sv
rtl/core/u8d_front.sv
rtl/core/u8d_queue.sv
rtl/core/u8d_back.sv
rtl/core/utf8_stream_decoder.sv
verif/utf8_stream_decoder_test.sv
